@@ hw/rtl/cst_pkg.sv @@
// Shared types, constants and character-class functions for the C source token scanner.
package cst_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE      = 3'd0,
        MODE_IDENT     = 3'd1,
        MODE_NUMBER    = 3'd2,
        MODE_STRING    = 3'd3,
        MODE_PAIR      = 3'd4,
        MODE_DONE      = 3'd5,
        MODE_DIRECTIVE = 3'd6
    } scan_mode_t;

    localparam logic [2:0] CLASS_IDENT    = 3'd0;
    localparam logic [2:0] CLASS_NUMBER   = 3'd1;
    localparam logic [2:0] CLASS_STRING   = 3'd2;
    localparam logic [2:0] CLASS_OPERATOR = 3'd3;
    localparam logic [2:0] CLASS_PUNCT    = 3'd4;
    localparam logic [2:0] CLASS_NEWLINE  = 3'd5;
    localparam logic [2:0] CLASS_OTHER    = 3'd6;

    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_EQUAL   = 8'h3D;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_BAR     = 8'h7C;
    localparam logic [7:0] CH_BANG    = 8'h21;
    localparam logic [7:0] CH_LT      = 8'h3C;
    localparam logic [7:0] CH_GT      = 8'h3E;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NL      = 8'h0A;

    // Flags that go with one emitted token byte
    typedef struct packed {
        logic       unterminated;
        logic       first;
        logic       last;
        logic [2:0] tok_class;
    } tok_flags_t;

    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    function automatic logic is_punct(input logic [7:0] b);
        return b >= 8'h21 && b <= 8'h7E && !is_alpha(b) && !is_digit(b);
    endfunction

    function automatic logic is_pair_head(input logic [7:0] b);
        return b == CH_EQUAL || b == CH_BANG || b == CH_AMP || b == CH_BAR ||
               b == CH_LT || b == CH_GT || b == CH_PLUS || b == CH_MINUS ||
               b == CH_SLASH || b == CH_STAR || b == CH_PERCENT;
    endfunction

    function automatic logic pairs_with(input logic [7:0] h, input logic [7:0] n);
        logic r;
        if (h == CH_AMP || h == CH_BAR)
            r = (n == h);
        else if (h == CH_PLUS || h == CH_MINUS)
            r = (n == CH_EQUAL) || (n == h);
        else
            r = (n == CH_EQUAL);
        return r;
    endfunction

endpackage

@@ hw/rtl/c_source_token_scanner.sv @@
// Top level of the C source token scanner: stream ports and output register with skid stage.
//
// Input stream s_*: one source byte per transaction in s_tdata; s_tlast high marks end of
// input, which flushes the held byte (s_tdata is then ignored).
// Output stream m_*: one token byte per transaction. m_tdata carries the byte, the token's
// start row and start column; m_tuser carries class, first mark and unterminated flag;
// m_tlast marks the final byte of a token.
// Each byte is held until the next transaction shows whether its token continues, so a
// token byte enters the output or skid register when the transaction that follows it (or the
// end-of-input transaction) is taken. Spaces, tabs and directive lines produce no output.
// Throughput is one transaction per cycle while s_tready is high; the scanner state is
// registered and the result lands in the output register, or in the skid register.
// When m_tready is low, one more result is caught in the skid register; s_tready drops
// only while the skid register is full.
// Reset clears the hold, sets row and column to 1 and empties both output registers.
module c_source_token_scanner #(
    parameter int ROW_BITS = 16,
    parameter int COL_BITS = 12
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // src_byte
    input  logic                  s_tlast,   // end_of_input
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // tok_char, start_row, start_col, zero pad
    output logic [((8 + ROW_BITS + COL_BITS + 7) / 8) * 8 - 1:0] m_tdata,
    output logic                  m_tlast,   // last_of_token
    output logic [4:0]            m_tuser    // tok_class[2:0], first_of_token, unterminated
);

    localparam int OUT_W = ((8 + ROW_BITS + COL_BITS + 7) / 8) * 8;

    logic                 in_fire;
    logic                 res_valid;
    logic [7:0]           res_char;
    logic [ROW_BITS-1:0]  res_row;
    logic [COL_BITS-1:0]  res_col;
    cst_pkg::tok_flags_t  res_flags;
    logic [OUT_W-1:0]     new_data;
    logic [4:0]           new_user;

    logic                 out_valid_reg;
    logic [OUT_W-1:0]     out_data_reg;
    logic [4:0]           out_user_reg;
    logic                 out_last_reg;
    logic                 skid_valid_reg;
    logic [OUT_W-1:0]     skid_data_reg;
    logic [4:0]           skid_user_reg;
    logic                 skid_last_reg;
    logic                 out_load;

    assign s_tready = !skid_valid_reg;
    assign in_fire  = s_tvalid && s_tready;
    assign out_load = !out_valid_reg || m_tready;

    cst_core #(
        .ROW_BITS (ROW_BITS),
        .COL_BITS (COL_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .in_byte   (s_tdata),
        .in_end    (s_tlast),
        .res_valid (res_valid),
        .res_char  (res_char),
        .res_row   (res_row),
        .res_col   (res_col),
        .res_flags (res_flags)
    );

    assign new_data = OUT_W'({res_col, res_row, res_char});
    assign new_user = {res_flags.unterminated, res_flags.first, res_flags.tok_class};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                // skid full means no transaction was taken this cycle
                out_valid_reg  <= skid_valid_reg || res_valid;
                skid_valid_reg <= 1'b0;
            end
            else if (res_valid)
                skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg <= skid_data_reg;
                out_user_reg <= skid_user_reg;
                out_last_reg <= skid_last_reg;
            end
            else
            begin
                out_data_reg <= new_data;
                out_user_reg <= new_user;
                out_last_reg <= res_flags.last;
            end
        end
        else if (res_valid)
        begin
            skid_data_reg <= new_data;
            skid_user_reg <= new_user;
            skid_last_reg <= res_flags.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

endmodule

@@ hw/rtl/cst_core.sv @@
// Scanner state: one-byte hold, token mode, position counters and per-byte result.
module cst_core #(
    parameter int ROW_BITS = 16,
    parameter int COL_BITS = 12
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_fire,
    input  logic [7:0]           in_byte,
    input  logic                 in_end,
    output logic                 res_valid,
    output logic [7:0]           res_char,
    output logic [ROW_BITS-1:0]  res_row,
    output logic [COL_BITS-1:0]  res_col,
    output cst_pkg::tok_flags_t  res_flags
);

    logic [7:0]           held_byte_reg,  held_byte_next;
    logic                 held_valid_reg, held_valid_next;
    logic                 held_first_reg, held_first_next;
    cst_pkg::scan_mode_t  mode_reg,       mode_next;
    logic [2:0]           class_reg,      class_next;
    logic [ROW_BITS-1:0]  line_reg,       line_next;
    logic [COL_BITS-1:0]  col_reg,        col_next;
    logic [ROW_BITS-1:0]  tok_row_reg,    tok_row_next;
    logic [COL_BITS-1:0]  tok_col_reg,    tok_col_next;

    logic cont;

    always_comb
    begin
        case (mode_reg)
            cst_pkg::MODE_IDENT:
                cont = cst_pkg::is_alpha(in_byte) || cst_pkg::is_digit(in_byte) ||
                       in_byte == cst_pkg::CH_UNDER;
            cst_pkg::MODE_NUMBER:
                cont = cst_pkg::is_digit(in_byte) || in_byte == cst_pkg::CH_DOT;
            cst_pkg::MODE_STRING:
                cont = 1'b1;
            cst_pkg::MODE_PAIR:
                cont = cst_pkg::pairs_with(held_byte_reg, in_byte);
            default:
                cont = 1'b0;
        endcase
    end

    // Next state
    always_comb
    begin
        held_byte_next  = held_byte_reg;
        held_valid_next = held_valid_reg;
        held_first_next = held_first_reg;
        mode_next       = mode_reg;
        class_next      = class_reg;
        line_next       = line_reg;
        col_next        = col_reg;
        tok_row_next    = tok_row_reg;
        tok_col_next    = tok_col_reg;
        if (in_fire)
        begin
            if (in_end)
            begin
                held_valid_next = 1'b0;
                held_first_next = 1'b0;
                mode_next       = cst_pkg::MODE_IDLE;
            end
            else
            begin
                if (held_valid_reg && cont)
                begin
                    held_byte_next  = in_byte;
                    held_first_next = 1'b0;
                    if (mode_reg == cst_pkg::MODE_PAIR ||
                        (mode_reg == cst_pkg::MODE_STRING && in_byte == cst_pkg::CH_QUOTE))
                        mode_next = cst_pkg::MODE_DONE;
                end
                else if (mode_reg == cst_pkg::MODE_DIRECTIVE && !held_valid_reg)
                begin
                    if (in_byte == cst_pkg::CH_NL)
                        mode_next = cst_pkg::MODE_IDLE;
                end
                else
                begin
                    held_valid_next = 1'b0;
                    if (in_byte == cst_pkg::CH_HASH)
                        mode_next = cst_pkg::MODE_DIRECTIVE;
                    else if (in_byte == cst_pkg::CH_SPACE || in_byte == cst_pkg::CH_TAB)
                        mode_next = cst_pkg::MODE_IDLE;
                    else
                    begin
                        held_byte_next  = in_byte;
                        held_valid_next = 1'b1;
                        held_first_next = 1'b1;
                        tok_row_next    = line_reg;
                        tok_col_next    = col_reg;
                        class_next      = cst_pkg::CLASS_OTHER;
                        mode_next       = cst_pkg::MODE_DONE;
                        if (in_byte == cst_pkg::CH_QUOTE)
                        begin
                            class_next = cst_pkg::CLASS_STRING;
                            mode_next  = cst_pkg::MODE_STRING;
                        end
                        else if (in_byte == cst_pkg::CH_NL)
                            class_next = cst_pkg::CLASS_NEWLINE;
                        else if (cst_pkg::is_pair_head(in_byte))
                        begin
                            class_next = cst_pkg::CLASS_OPERATOR;
                            mode_next  = cst_pkg::MODE_PAIR;
                        end
                        else if (cst_pkg::is_alpha(in_byte) || in_byte == cst_pkg::CH_UNDER)
                        begin
                            class_next = cst_pkg::CLASS_IDENT;
                            mode_next  = cst_pkg::MODE_IDENT;
                        end
                        else if (cst_pkg::is_digit(in_byte))
                        begin
                            class_next = cst_pkg::CLASS_NUMBER;
                            mode_next  = cst_pkg::MODE_NUMBER;
                        end
                        else if (cst_pkg::is_punct(in_byte))
                            class_next = cst_pkg::CLASS_PUNCT;
                    end
                end
                // saturating position of the next byte
                if (in_byte == cst_pkg::CH_NL)
                begin
                    if (line_reg != {ROW_BITS{1'b1}})
                        line_next = line_reg + ROW_BITS'(1);
                    col_next = COL_BITS'(1);
                end
                else if (col_reg != {COL_BITS{1'b1}})
                    col_next = col_reg + COL_BITS'(1);
            end
        end
    end

    // Outputs: the held byte leaves when any byte or the end marker arrives
    always_comb
    begin
        res_valid              = in_fire && held_valid_reg;
        res_char               = held_byte_reg;
        res_row                = tok_row_reg;
        res_col                = tok_col_reg;
        res_flags.tok_class    = class_reg;
        res_flags.first        = held_first_reg;
        res_flags.last         = in_end || !cont;
        res_flags.unterminated = in_end && mode_reg == cst_pkg::MODE_STRING;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_byte_reg  <= 8'h00;
            held_valid_reg <= 1'b0;
            held_first_reg <= 1'b0;
            mode_reg       <= cst_pkg::MODE_IDLE;
            class_reg      <= cst_pkg::CLASS_IDENT;
            line_reg       <= ROW_BITS'(1);
            col_reg        <= COL_BITS'(1);
            tok_row_reg    <= ROW_BITS'(1);
            tok_col_reg    <= COL_BITS'(1);
        end
        else
        begin
            held_byte_reg  <= held_byte_next;
            held_valid_reg <= held_valid_next;
            held_first_reg <= held_first_next;
            mode_reg       <= mode_next;
            class_reg      <= class_next;
            line_reg       <= line_next;
            col_reg        <= col_next;
            tok_row_reg    <= tok_row_next;
            tok_col_reg    <= tok_col_next;
        end
    end

endmodule

@@ verif/tb_c_source_token_scanner.sv @@
// Self-checking testbench for the C source token scanner: byte stream in, checked token bytes out.
`timescale 1ns / 1ps

module tb_c_source_token_scanner;

    localparam int ROW_BITS  = 16;
    localparam int COL_BITS  = 12;
    localparam int DATA_BITS = 8 + ROW_BITS + COL_BITS;
    localparam int OUT_W     = ((DATA_BITS + 7) / 8) * 8;
    localparam int PAD_W     = OUT_W - DATA_BITS;
    localparam int TOTAL_ITEMS = 1550;

    // One token byte as it leaves the block
    typedef struct packed {
        logic [7:0]          ch;
        logic [2:0]          cls;
        logic [ROW_BITS-1:0] row;
        logic [COL_BITS-1:0] col;
        logic                first;
        logic                last;
        logic                unterm;
        logic [PAD_W-1:0]    pad;
    } tok_beat_t;

    class token_stream_tracker;
        tok_beat_t           pending_bytes[$];
        int                  errors;
        int                  checked;
        int                  unterm_seen;

        logic [7:0]          held_byte;
        bit                  held_valid;
        bit                  held_first;
        cst_pkg::scan_mode_t mode;
        logic [2:0]          cur_class;
        logic [ROW_BITS-1:0] line_no;
        logic [COL_BITS-1:0] col_no;
        logic [ROW_BITS-1:0] tok_row;
        logic [COL_BITS-1:0] tok_col;

        function new();
            errors      = 0;
            checked     = 0;
            unterm_seen = 0;
            held_byte   = 8'h00;
            held_valid  = 1'b0;
            held_first  = 1'b0;
            mode        = cst_pkg::MODE_IDLE;
            cur_class   = cst_pkg::CLASS_IDENT;
            line_no     = ROW_BITS'(1);
            col_no      = COL_BITS'(1);
            tok_row     = ROW_BITS'(1);
            tok_col     = COL_BITS'(1);
        endfunction

        function bit letter(logic [7:0] b);
            return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
        endfunction

        function bit numeral(logic [7:0] b);
            return b >= "0" && b <= "9";
        endfunction

        function bit op_head(logic [7:0] b);
            return b == cst_pkg::CH_EQUAL || b == cst_pkg::CH_BANG || b == cst_pkg::CH_AMP ||
                   b == cst_pkg::CH_BAR || b == cst_pkg::CH_LT || b == cst_pkg::CH_GT ||
                   b == cst_pkg::CH_PLUS || b == cst_pkg::CH_MINUS ||
                   b == cst_pkg::CH_SLASH || b == cst_pkg::CH_STAR ||
                   b == cst_pkg::CH_PERCENT;
        endfunction

        function bit extends_token(logic [7:0] b);
            case (mode)
                cst_pkg::MODE_IDENT:  return letter(b) || numeral(b) || b == cst_pkg::CH_UNDER;
                cst_pkg::MODE_NUMBER: return numeral(b) || b == cst_pkg::CH_DOT;
                cst_pkg::MODE_STRING: return 1'b1;
                cst_pkg::MODE_PAIR:
                    if (held_byte == cst_pkg::CH_AMP || held_byte == cst_pkg::CH_BAR)
                        return b == held_byte;
                    else if (held_byte == cst_pkg::CH_PLUS || held_byte == cst_pkg::CH_MINUS)
                        return b == cst_pkg::CH_EQUAL || b == held_byte;
                    else
                        return b == cst_pkg::CH_EQUAL;
                default:     return 1'b0;
            endcase
        endfunction

        function void open_token(logic [7:0] b);
            logic [2:0] cls;
            cst_pkg::scan_mode_t nxt;
            cls = cst_pkg::CLASS_OTHER;
            nxt = cst_pkg::MODE_DONE;
            held_valid = 1'b0;
            if (b == cst_pkg::CH_HASH) begin
                mode = cst_pkg::MODE_DIRECTIVE;
                return;
            end
            if (b == cst_pkg::CH_SPACE || b == cst_pkg::CH_TAB) begin
                mode = cst_pkg::MODE_IDLE;
                return;
            end
            if (b == cst_pkg::CH_QUOTE) begin
                cls = cst_pkg::CLASS_STRING;
                nxt = cst_pkg::MODE_STRING;
            end else if (b == cst_pkg::CH_NL) begin
                cls = cst_pkg::CLASS_NEWLINE;
            end else if (op_head(b)) begin
                cls = cst_pkg::CLASS_OPERATOR;
                nxt = cst_pkg::MODE_PAIR;
            end else if (letter(b) || b == cst_pkg::CH_UNDER) begin
                cls = cst_pkg::CLASS_IDENT;
                nxt = cst_pkg::MODE_IDENT;
            end else if (numeral(b)) begin
                cls = cst_pkg::CLASS_NUMBER;
                nxt = cst_pkg::MODE_NUMBER;
            end else if (b >= 8'h21 && b <= 8'h7E) begin
                cls = cst_pkg::CLASS_PUNCT;
            end
            held_byte  = b;
            held_valid = 1'b1;
            held_first = 1'b1;
            cur_class  = cls;
            mode       = nxt;
            tok_row    = line_no;
            tok_col    = col_no;
        endfunction

        function void push_beat(bit last, bit unterm);
            tok_beat_t beat;
            beat.ch     = held_byte;
            beat.cls    = cur_class;
            beat.row    = tok_row;
            beat.col    = tok_col;
            beat.first  = held_first;
            beat.last   = last;
            beat.unterm = unterm;
            beat.pad    = '0;
            pending_bytes.push_back(beat);
        endfunction

        // Advance the scan by one accepted input transaction
        function void note_source_byte(logic [7:0] b, bit eoi);
            bit cont;
            bit closing;
            cont = 1'b0;
            if (eoi) begin
                if (held_valid)
                    push_beat(1'b1, mode == cst_pkg::MODE_STRING);
                held_valid = 1'b0;
                held_first = 1'b0;
                mode       = cst_pkg::MODE_IDLE;
                return;
            end
            if (held_valid) begin
                cont = extends_token(b);
                push_beat(!cont, 1'b0);
            end
            if (cont) begin
                closing    = (mode == cst_pkg::MODE_STRING && b == cst_pkg::CH_QUOTE);
                held_byte  = b;
                held_first = 1'b0;
                if (mode == cst_pkg::MODE_PAIR || closing)
                    mode = cst_pkg::MODE_DONE;
            end else if (mode == cst_pkg::MODE_DIRECTIVE && !held_valid) begin
                if (b == cst_pkg::CH_NL)
                    mode = cst_pkg::MODE_IDLE;
            end else begin
                open_token(b);
            end
            if (b == cst_pkg::CH_NL) begin
                if (line_no != '1)
                    line_no++;
                col_no = COL_BITS'(1);
            end else if (col_no != '1) begin
                col_no++;
            end
        endfunction

        function void field_check(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            end
        endfunction

        function void check_token_byte(tok_beat_t got);
            tok_beat_t want;
            checked++;
            if (got.unterm)
                unterm_seen++;
            if (pending_bytes.size() == 0) begin
                errors++;
                $display("%0t: unexpected token byte, expected none actual %0h", $time, got.ch);
                return;
            end
            want = pending_bytes.pop_front();
            field_check("tok_char", 32'(want.ch), 32'(got.ch));
            field_check("tok_class", 32'(want.cls), 32'(got.cls));
            field_check("start_row", 32'(want.row), 32'(got.row));
            field_check("start_col", 32'(want.col), 32'(got.col));
            field_check("first_of_token", 32'(want.first), 32'(got.first));
            field_check("last_of_token", 32'(want.last), 32'(got.last));
            field_check("unterminated", 32'(want.unterm), 32'(got.unterm));
            field_check("tdata pad", 32'(want.pad), 32'(got.pad));
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [7:0]       s_tdata = 8'h00;
    logic             s_tlast = 1'b0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic             m_tlast;
    logic [4:0]       m_tuser;

    token_stream_tracker tracker = new();
    bit calm = 1'b0;
    int items_sent = 0;

    c_source_token_scanner #(
        .ROW_BITS(ROW_BITS),
        .COL_BITS(COL_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),   // src_byte
        .s_tlast(s_tlast),   // end_of_input
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),   // tok_char, start_row, start_col, zero pad
        .m_tlast(m_tlast),   // last_of_token
        .m_tuser(m_tuser)    // tok_class[2:0], first_of_token, unterminated
    );

    always #5 clk = ~clk;

    // Called at a rising edge; returns at the edge where the transaction is taken
    task automatic send_item(input logic [7:0] b, input logic eoi);
        bit taken;
        while (!calm && $urandom_range(99) < 31) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eoi;
        do begin
            @(negedge clk);
            taken = s_tready;
            @(posedge clk);
        end while (!taken);
        tracker.note_source_byte(b, eoi);
        items_sent++;
    endtask

    task automatic send_str(input string s);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], 1'b0);
    endtask

    task automatic send_end();
        send_item(8'($urandom_range(255)), 1'b1);
    endtask

    function automatic logic [7:0] pick_letter();
        if ($urandom_range(4) == 0)
            return cst_pkg::CH_UNDER;
        return $urandom_range(1) ? 8'("a" + $urandom_range(25)) : 8'("A" + $urandom_range(25));
    endfunction

    function automatic logic [7:0] pick_string_byte();
        logic [7:0] b;
        int roll;
        roll = $urandom_range(99);
        if (roll < 70)
            b = 8'($urandom_range(8'h7E, 8'h20));
        else if (roll < 80)
            b = cst_pkg::CH_NL;
        else
            b = 8'($urandom_range(255));
        return (b == cst_pkg::CH_QUOTE) ? 8'h71 : b;
    endfunction

    // One well-formed token or separator with random content, now and then noise or an end of input
    task automatic send_random_token();
        string pairs[13] = '{"==", "!=", "&&", "||", "<=", ">=", "+=", "++", "-=", "--",
                             "/=", "*=", "%="};
        string heads = "!&|<>+-/*%=";
        string puncts = "();,{}[].:?~^@$`'\\";
        int kind;
        int len;
        logic [7:0] b;
        kind = $urandom_range(99);
        len  = $urandom_range(6);
        if (kind < 20) begin
            send_item(pick_letter(), 1'b0);
            repeat (len)
                send_item($urandom_range(3) == 0 ? 8'("0" + $urandom_range(9)) : pick_letter(),
                          1'b0);
        end else if (kind < 32) begin
            send_item(8'("0" + $urandom_range(9)), 1'b0);
            repeat (len)
                send_item($urandom_range(3) == 0 ? cst_pkg::CH_DOT : 8'("0" + $urandom_range(9)),
                          1'b0);
        end else if (kind < 42 || kind >= 97) begin
            send_item(cst_pkg::CH_QUOTE, 1'b0);
            repeat ($urandom_range(8))
                send_item(pick_string_byte(), 1'b0);
            if (kind >= 97)
                send_end();
            else
                send_item(cst_pkg::CH_QUOTE, 1'b0);
        end else if (kind < 55) begin
            if ($urandom_range(1))
                send_str(pairs[$urandom_range(12)]);
            else
                send_item(heads[$urandom_range(heads.len() - 1)], 1'b0);
        end else if (kind < 63) begin
            send_item(puncts[$urandom_range(puncts.len() - 1)], 1'b0);
        end else if (kind < 75) begin
            repeat ($urandom_range(3, 1))
                send_item($urandom_range(1) ? cst_pkg::CH_SPACE : cst_pkg::CH_TAB, 1'b0);
        end else if (kind < 81) begin
            send_item(cst_pkg::CH_NL, 1'b0);
        end else if (kind < 86) begin
            send_item(cst_pkg::CH_HASH, 1'b0);
            repeat (len) begin
                b = 8'($urandom_range(255));
                send_item(b == cst_pkg::CH_NL ? cst_pkg::CH_SPACE : b, 1'b0);
            end
            send_item(cst_pkg::CH_NL, 1'b0);
        end else if (kind < 95) begin
            send_item(8'($urandom_range(255)), 1'b0);
        end else begin
            send_end();
        end
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: ident with underscore, tab, number with dot
        send_str("_aZ9\t0.5");
        send_str("+=;");
        send_item(8'h80, 1'b0);
        // directive line gives nothing, its newline still counts
        send_str("#x\n");
        // string spanning a newline, closed by end of input
        send_str("\"a\nb");
        send_end();
        send_item(8'hFF, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(cst_pkg::CH_NL, 1'b0);
        send_end();
        // end with nothing held
        send_end();

        while (items_sent < TOTAL_ITEMS) begin
            calm = (items_sent >= 600 && items_sent < 900);
            send_random_token();
        end
        calm = 1'b0;

        send_end();
        s_tvalid <= 1'b0;

        while (tracker.pending_bytes.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Sent %0d source bytes; checked %0d token bytes (%0d unterminated),",
                 items_sent, tracker.checked, tracker.unterm_seen);
        $display("including directives, strings across lines and end-of-input flushes.");
        if (tracker.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Output side: random back-pressure, one long hold-off to fill the skid stage
    initial begin
        bit fire;
        bit pressed;
        int hold_left;
        tok_beat_t got;
        fire = 1'b0;
        pressed = 1'b0;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (fire)
                tracker.check_token_byte(got);
            if (!pressed && tracker.checked >= 250) begin
                pressed = 1'b1;
                hold_left = 80;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (calm) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(99) >= 31);
            end
            @(negedge clk);
            fire       = rst_n && m_tvalid && m_tready;
            got.ch     = m_tdata[7:0];
            got.row    = m_tdata[8 +: ROW_BITS];
            got.col    = m_tdata[8 + ROW_BITS +: COL_BITS];
            got.pad    = m_tdata[OUT_W-1:DATA_BITS];
            got.cls    = m_tuser[2:0];
            got.first  = m_tuser[3];
            got.unterm = m_tuser[4];
            got.last   = m_tlast;
        end
    end

    initial begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

@@ c_source_token_scanner.f @@
hw/rtl/cst_pkg.sv
hw/rtl/cst_core.sv
hw/rtl/c_source_token_scanner.sv
verif/tb_c_source_token_scanner.sv
